>>> src/jsu_pkg.sv
package jsu_pkg;

  // Result status codes as they appear on the status port.
  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  // Number of code point slots in one job; one input byte fills at most two.
  localparam int unsigned MaxUnits = 3;

  localparam logic [20:0] CpReplacement = 21'h00FFFD;
  localparam logic [20:0] CpSupplBase   = 21'h010000;
  localparam logic [20:0] Cp2ByteLimit  = 21'h000080;
  localparam logic [20:0] Cp3ByteLimit  = 21'h000800;
  localparam logic [20:0] Cp4ByteLimit  = 21'h010000;

  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Lead4 = 8'hF0;
  localparam logic [7:0] Utf8Cont  = 8'h80;

  // One decode job: up to three code points or raw bytes, then an optional
  // terminal status. len holds the UTF-8 byte count minus one.
  typedef struct packed {
    logic [MaxUnits-1:0][20:0] cp;
    logic [MaxUnits-1:0]       raw;
    logic [MaxUnits-1:0][1:0]  len;
    logic [1:0]                n;
    logic                      term_vld;
    status_e                   term;
  } job_t;

  // UTF-8 byte count minus one for a code point.
  function automatic logic [1:0] utf8_len(logic [20:0] cp);
    logic [1:0] l;
    if (cp < Cp2ByteLimit) begin
      l = 2'd0;
    end else if (cp < Cp3ByteLimit) begin
      l = 2'd1;
    end else if (cp < Cp4ByteLimit) begin
      l = 2'd2;
    end else begin
      l = 2'd3;
    end
    return l;
  endfunction

  // Byte k of the encoding of one unit.
  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic raw, logic [1:0] len,
                                           logic [1:0] k);
    logic [7:0] b;
    b = cp[7:0];
    if (!raw) begin
      case (len)
        2'd0: b = {1'b0, cp[6:0]};
        2'd1: b = (k == 2'd0) ? (Utf8Lead2 | {3'b000, cp[10:6]}) : (Utf8Cont | {2'b00, cp[5:0]});
        2'd2: begin
          case (k)
            2'd0:    b = Utf8Lead3 | {4'b0000, cp[15:12]};
            2'd1:    b = Utf8Cont | {2'b00, cp[11:6]};
            default: b = Utf8Cont | {2'b00, cp[5:0]};
          endcase
        end
        default: begin
          case (k)
            2'd0:    b = Utf8Lead4 | {5'b00000, cp[20:18]};
            2'd1:    b = Utf8Cont | {2'b00, cp[17:12]};
            2'd2:    b = Utf8Cont | {2'b00, cp[11:6]};
            default: b = Utf8Cont | {2'b00, cp[5:0]};
          endcase
        end
      endcase
    end
    return b;
  endfunction

  // Appends one unit to a job.
  function automatic job_t push_unit(job_t j, logic [20:0] cp, logic raw);
    job_t r;
    r = j;
    r.cp[j.n]  = cp;
    r.raw[j.n] = raw;
    r.len[j.n] = raw ? 2'd0 : utf8_len(cp);
    r.n        = 2'(j.n + 2'd1);
    return r;
  endfunction

endpackage

>>> src/jsu_front.sv
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          last_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output jsu_pkg::job_t job_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_TEXT,
    MODE_ESC,
    MODE_HEX,
    MODE_PAIR,
    MODE_PAIRBS,
    MODE_LOWHEX
  } mode_e;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] CtrlLimit = 8'h20;
  localparam logic [5:0] HighSurrTag = 6'b110110;
  localparam logic [5:0] LowSurrTag  = 6'b110111;

  mode_e       mode_q, mode_d;
  logic [11:0] hex_q, hex_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  held_q, held_d;
  job_t        job;
  logic        accept;

  // Hex digit value with a valid flag in the top bit.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;
  assign job_o      = job;
  assign push_o     = accept && ((job.n != 2'd0) || job.term_vld);

  // Next decode state and the job caused by the current byte.
  always_comb begin
    logic [4:0]  dig;
    logic [15:0] val;
    logic        do_text;
    logic        do_esc;
    logic        do_take;
    mode_d  = mode_q;
    hex_d   = hex_q;
    cnt_d   = cnt_q;
    held_d  = held_q;
    job     = '0;
    dig     = hex_digit(in_byte_i);
    val     = {hex_q, dig[3:0]};
    do_text = 1'b0;
    do_esc  = 1'b0;
    do_take = 1'b0;

    case (mode_q)
      MODE_IDLE: begin
        if (in_byte_i == ChQuote) mode_d = MODE_TEXT;
      end
      MODE_TEXT: do_text = 1'b1;
      MODE_ESC:  do_esc = 1'b1;
      MODE_HEX: begin
        if (!dig[4]) begin
          job.term_vld = 1'b1;
          job.term     = ST_ERROR;
          mode_d       = MODE_IDLE;
        end else if (cnt_q != 2'd3) begin
          hex_d = {hex_q[7:0], dig[3:0]};
          cnt_d = 2'(cnt_q + 2'd1);
        end else begin
          do_take = 1'b1;
        end
      end
      MODE_PAIR: begin
        if (in_byte_i == ChBslash) begin
          mode_d = MODE_PAIRBS;
        end else begin
          job     = push_unit(job, CpReplacement, 1'b0);
          do_text = 1'b1;
        end
      end
      MODE_PAIRBS: begin
        if (in_byte_i == ChU) begin
          hex_d  = '0;
          cnt_d  = '0;
          mode_d = MODE_LOWHEX;
        end else begin
          job    = push_unit(job, CpReplacement, 1'b0);
          do_esc = 1'b1;
        end
      end
      MODE_LOWHEX: begin
        if (!dig[4]) begin
          job          = push_unit(job, CpReplacement, 1'b0);
          job.term_vld = 1'b1;
          job.term     = ST_ERROR;
          mode_d       = MODE_IDLE;
        end else if (cnt_q != 2'd3) begin
          hex_d = {hex_q[7:0], dig[3:0]};
          cnt_d = 2'(cnt_q + 2'd1);
        end else if (val[15:10] == LowSurrTag) begin
          job    = push_unit(job, CpSupplBase + {1'b0, held_q, val[9:0]}, 1'b0);
          hex_d  = '0;
          cnt_d  = '0;
          mode_d = MODE_TEXT;
        end else begin
          job     = push_unit(job, CpReplacement, 1'b0);
          do_take = 1'b1;
        end
      end
      default: begin
        job.term_vld = 1'b1;
        job.term     = ST_ERROR;
        mode_d       = MODE_IDLE;
      end
    endcase

    // A completed four-digit escape value.
    if (do_take) begin
      hex_d = '0;
      cnt_d = '0;
      if (val[15:10] == HighSurrTag) begin
        held_d = val[9:0];
        mode_d = MODE_PAIR;
      end else if (val[15:10] == LowSurrTag) begin
        job    = push_unit(job, CpReplacement, 1'b0);
        mode_d = MODE_TEXT;
      end else begin
        job    = push_unit(job, {5'b00000, val}, 1'b0);
        mode_d = MODE_TEXT;
      end
    end

    // A byte of plain string text.
    if (do_text) begin
      if (in_byte_i == ChQuote) begin
        job.term_vld = 1'b1;
        job.term     = ST_DONE;
        mode_d       = MODE_IDLE;
      end else if (in_byte_i < CtrlLimit) begin
        job.term_vld = 1'b1;
        job.term     = ST_ERROR;
        mode_d       = MODE_IDLE;
      end else if (in_byte_i == ChBslash) begin
        mode_d = MODE_ESC;
      end else begin
        job    = push_unit(job, {13'd0, in_byte_i}, 1'b1);
        mode_d = MODE_TEXT;
      end
    end

    // The letter after a backslash.
    if (do_esc) begin
      mode_d = MODE_TEXT;
      case (in_byte_i)
        ChQuote:  job = push_unit(job, {13'd0, ChQuote}, 1'b1);
        ChBslash: job = push_unit(job, {13'd0, ChBslash}, 1'b1);
        ChSlash:  job = push_unit(job, {13'd0, ChSlash}, 1'b1);
        ChB:      job = push_unit(job, 21'h08, 1'b1);
        ChF:      job = push_unit(job, 21'h0C, 1'b1);
        ChN:      job = push_unit(job, 21'h0A, 1'b1);
        ChR:      job = push_unit(job, 21'h0D, 1'b1);
        ChT:      job = push_unit(job, 21'h09, 1'b1);
        ChU: begin
          hex_d  = '0;
          cnt_d  = '0;
          mode_d = MODE_HEX;
        end
        default: begin
          job.term_vld = 1'b1;
          job.term     = ST_ERROR;
          mode_d       = MODE_IDLE;
        end
      endcase
    end

    // Text that ends inside the string is an error.
    if (last_byte_i && (mode_d != MODE_IDLE)) begin
      if ((mode_d == MODE_PAIR) || (mode_d == MODE_PAIRBS) || (mode_d == MODE_LOWHEX)) begin
        job = push_unit(job, CpReplacement, 1'b0);
      end
      job.term_vld = 1'b1;
      job.term     = ST_ERROR;
      mode_d       = MODE_IDLE;
    end

    if (mode_d == MODE_IDLE) begin
      hex_d  = '0;
      cnt_d  = '0;
      held_d = '0;
    end
  end

  // Decode state advances once per accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      hex_q  <= '0;
      cnt_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      cnt_q  <= cnt_d;
      held_q <= held_d;
    end
  end

endmodule

>>> src/jsu_queue.sv
module jsu_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output jsu_pkg::job_t pop_data_o,
  output logic          empty_o
);
  import jsu_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  job_t             mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  // Storage of queued jobs.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastAddr) ? '0 : AddrW'(wr_q + 1'b1);
      if (do_pop)  rd_q <= (rd_q == LastAddr) ? '0 : AddrW'(rd_q + 1'b1);
      if (do_push && !do_pop) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

endmodule

>>> src/jsu_back.sv
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  jsu_pkg::job_t q_data_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic [1:0]    status_o,
  output logic          run_end_o
);
  import jsu_pkg::*;

  logic       busy_q;
  job_t       job_q;
  logic [1:0] unit_q;
  logic [1:0] byte_q;
  logic       in_unit, unit_last, res_last, take, load;
  logic [1:0] cur_len;

  assign in_unit   = (unit_q < job_q.n);
  assign cur_len   = job_q.len[unit_q];
  assign unit_last = (byte_q == cur_len);
  assign res_last  = in_unit ? (unit_last && (2'(unit_q + 2'd1) == job_q.n) && !job_q.term_vld)
                             : 1'b1;
  assign take      = busy_q && out_ready_i;
  assign load      = !busy_q || (take && res_last);
  assign pop_o     = load && !q_empty_i;

  // Result fields come straight from the held job and position.
  assign out_valid_o = busy_q;
  assign out_byte_o  = in_unit ? utf8_byte(job_q.cp[unit_q], job_q.raw[unit_q], cur_len, byte_q)
                               : 8'd0;
  assign status_o    = in_unit ? ST_BYTE : job_q.term;
  assign run_end_o   = res_last;

  // Position within the held job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      unit_q <= '0;
      byte_q <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      unit_q <= '0;
      byte_q <= '0;
    end else if (load) begin
      busy_q <= 1'b0;
    end else if (take) begin
      if (unit_last) begin
        unit_q <= 2'(unit_q + 2'd1);
        byte_q <= '0;
      end else begin
        byte_q <= 2'(byte_q + 2'd1);
      end
    end
  end

  // Job payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= q_data_i;
  end

endmodule

>>> src/json_string_unescape_utf8_unit.sv
// Streaming JSON string unescaper. Feed the bytes of one quoted string
// literal, opening quote first, and it returns the decoded text as UTF-8
// bytes, followed by one completion or error result; run_end marks the last
// result caused by each input byte. Input bytes are taken one per cycle while
// the job queue between decoder and serializer has room (QueueDepth entries,
// so a burst of that many input bytes is absorbed while the output stalls).
// The serializer gives one result per cycle while out_ready_i is high, so the
// results of one byte, one to seven, leave back to back; a byte that causes
// none costs nothing downstream. Each job passes the queue and a job register.
module json_string_unescape_utf8_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       run_end_o
);
  import jsu_pkg::*;

  job_t push_job, pop_job;
  logic push, q_full, pop, q_empty;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (q_empty)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .run_end_o   (run_end_o)
  );

endmodule

>>> src/jsu_checker.sv
module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] status_i,
  input logic       run_end_i
);
  import jsu_pkg::*;

  // A stalled result holds its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
    $stable(status_i) && $stable(run_end_i))
    else $error("stalled result changed");

  // Completion and error results carry a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_BYTE) |-> out_byte_i == 8'd0)
    else $error("status result with nonzero byte");

  // A completion or error closes the run of its input byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_BYTE) |-> run_end_i)
    else $error("status result not last of run");

  // The unused status code never appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ST_BYTE) || (status_i == ST_DONE) || (status_i == ST_ERROR))
    else $error("bad status code");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_i  (out_byte_o),
  .status_i    (status_o),
  .run_end_i   (run_end_o)
);

>>> tb/json_string_unescape_utf8_unit_test.sv
module json_string_unescape_utf8_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int ItemTarget  = 410;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 20;
  localparam int HoldAt      = 100;
  localparam int HoldCycles  = 60;

  localparam logic [20:0] ReplCp  = 21'h00FFFD;
  localparam logic [20:0] SupplCp = 21'h010000;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChU         = 8'h75;

  typedef enum logic [2:0] {
    DM_IDLE,
    DM_TEXT,
    DM_ESC,
    DM_HEX,
    DM_PAIR,
    DM_PAIRBS,
    DM_LOWHEX
  } dmode_e;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic [7:0] b;
    status_e    st;
    logic       run_end;
  } decoded_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] status_o;
  logic       run_end_o;

  // Decoder state as predicted.
  dmode_e      dmode = DM_IDLE;
  logic [15:0] hacc = '0;
  logic [1:0]  hcnt = '0;
  logic [9:0]  held = '0;

  text_item_t text_q[$];
  logic [7:0] str_q[$];
  decoded_t   byte_results_q[$];
  decoded_t   decoded_q[$];

  int mismatches = 0;
  int in_count = 0;
  int out_count = 0;
  int stall_cycles = 0;

  json_string_unescape_utf8_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .last_byte_i(last_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .status_o   (status_o),
    .run_end_o  (run_end_o)
  );

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 100) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  // ---------------------------------------------------------------------
  // Decode prediction.
  // ---------------------------------------------------------------------

  function automatic void emit(logic [7:0] b, status_e st);
    decoded_t r;
    r = '{b: b, st: st, run_end: 1'b0};
    byte_results_q = {byte_results_q, r};
  endfunction

  // UTF-8 encoding of one code point.
  function automatic void emit_cp(logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0], ST_BYTE);
    end else if (cp < 21'h800) begin
      emit(8'hC0 | {3'b000, cp[10:6]}, ST_BYTE);
      emit(8'h80 | {2'b00, cp[5:0]}, ST_BYTE);
    end else if (cp < 21'h10000) begin
      emit(8'hE0 | {4'b0000, cp[15:12]}, ST_BYTE);
      emit(8'h80 | {2'b00, cp[11:6]}, ST_BYTE);
      emit(8'h80 | {2'b00, cp[5:0]}, ST_BYTE);
    end else begin
      emit(8'hF0 | {5'b00000, cp[20:18]}, ST_BYTE);
      emit(8'h80 | {2'b00, cp[17:12]}, ST_BYTE);
      emit(8'h80 | {2'b00, cp[11:6]}, ST_BYTE);
      emit(8'h80 | {2'b00, cp[5:0]}, ST_BYTE);
    end
  endfunction

  // Terminal result; the decoder then waits for a new opening quote.
  function automatic void end_string(status_e st);
    emit(8'h00, st);
    dmode = DM_IDLE;
    hacc  = '0;
    hcnt  = '0;
    held  = '0;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    int d;
    d = -1;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
    return d;
  endfunction

  function automatic logic known_escape(logic [7:0] c);
    return c == ChQuote || c == ChBackslash || c == ChSlash || c == ChB || c == ChF ||
           c == ChN || c == ChR || c == ChT || c == ChU;
  endfunction

  function automatic void text_byte(logic [7:0] c);
    if (c == ChQuote) end_string(ST_DONE);
    else if (c < 8'h20) end_string(ST_ERROR);
    else if (c == ChBackslash) dmode = DM_ESC;
    else emit(c, ST_BYTE);
  endfunction

  function automatic void escape_letter(logic [7:0] c);
    logic [7:0] b;
    logic       simple;
    b      = c;
    simple = 1'b1;
    case (c)
      ChQuote, ChBackslash, ChSlash: b = c;
      ChB: b = 8'h08;
      ChF: b = 8'h0C;
      ChN: b = 8'h0A;
      ChR: b = 8'h0D;
      ChT: b = 8'h09;
      ChU: begin
        hacc   = '0;
        hcnt   = '0;
        dmode  = DM_HEX;
        simple = 1'b0;
      end
      default: begin
        end_string(ST_ERROR);
        simple = 1'b0;
      end
    endcase
    if (simple) begin
      emit(b, ST_BYTE);
      dmode = DM_TEXT;
    end
  endfunction

  // A complete first escape value: hold a high surrogate, replace a lone low one.
  function automatic void take_value(logic [15:0] v);
    if (v >= 16'hD800 && v < 16'hDC00) begin
      held  = 10'(v - 16'hD800);
      dmode = DM_PAIR;
    end else if (v >= 16'hDC00 && v < 16'hE000) begin
      emit_cp(ReplCp);
      dmode = DM_TEXT;
    end else begin
      emit_cp({5'b00000, v});
      dmode = DM_TEXT;
    end
  endfunction

  // Returns 1 with v set when four digits are in, 0 when more are needed, -1 on a bad digit.
  function automatic int gather(logic [7:0] c, output logic [15:0] v);
    int d;
    d = hex_digit(c);
    v = '0;
    if (d < 0) return -1;
    if (hcnt < 2'd3) begin
      hacc = {hacc[11:0], 4'(d)};
      hcnt = hcnt + 2'd1;
      return 0;
    end
    v    = {hacc[11:0], 4'(d)};
    hacc = '0;
    hcnt = '0;
    return 1;
  endfunction

  // Works out every result one accepted text byte causes.
  function automatic void decode_byte(logic [7:0] c, logic last);
    logic [15:0] v;
    int          g;
    byte_results_q = {};
    case (dmode)
      DM_IDLE: begin
        if (c == ChQuote) dmode = DM_TEXT;
      end
      DM_TEXT: text_byte(c);
      DM_ESC:  escape_letter(c);
      DM_HEX: begin
        g = gather(c, v);
        if (g < 0) end_string(ST_ERROR);
        else if (g > 0) take_value(v);
      end
      DM_PAIR: begin
        if (c == ChBackslash) begin
          dmode = DM_PAIRBS;
        end else begin
          emit_cp(ReplCp);
          dmode = DM_TEXT;
          text_byte(c);
        end
      end
      DM_PAIRBS: begin
        if (c == ChU) begin
          hacc  = '0;
          hcnt  = '0;
          dmode = DM_LOWHEX;
        end else begin
          emit_cp(ReplCp);
          dmode = DM_ESC;
          escape_letter(c);
        end
      end
      DM_LOWHEX: begin
        g = gather(c, v);
        if (g < 0) begin
          emit_cp(ReplCp);
          end_string(ST_ERROR);
        end else if (g > 0) begin
          if (v >= 16'hDC00 && v < 16'hE000) begin
            emit_cp(SupplCp + {held, 10'(v - 16'hDC00)});
            dmode = DM_TEXT;
          end else begin
            emit_cp(ReplCp);
            take_value(v);
          end
        end
      end
      default: end_string(ST_ERROR);
    endcase

    // Text that ends before the closing quote.
    if (last && dmode != DM_IDLE) begin
      if (dmode == DM_PAIR || dmode == DM_PAIRBS || dmode == DM_LOWHEX) emit_cp(ReplCp);
      end_string(ST_ERROR);
    end

    if (byte_results_q.size() > 0) begin
      byte_results_q[byte_results_q.size() - 1].run_end = 1'b1;
    end
    decoded_q = {decoded_q, byte_results_q};
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------

  // Appends one byte to the string being built.
  function automatic void add_char(logic [7:0] c);
    str_q = {str_q, c};
  endfunction

  function automatic void flush_string(logic last_flag);
    text_item_t t;
    foreach (str_q[i]) begin
      t = '{b: str_q[i], last: (i == str_q.size() - 1) ? last_flag : 1'b0};
      text_q = {text_q, t};
    end
    str_q = {};
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  // Biased toward the ends of the range.
  function automatic int pick_in(int lo, int hi);
    int r;
    case ($urandom_range(0, 7))
      0:       r = lo;
      1:       r = hi;
      default: r = $urandom_range(lo, hi);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + n;
  endfunction

  function automatic void add_hex(logic [15:0] v);
    add_char(ChBackslash);
    add_char(ChU);
    for (int i = 3; i >= 0; i--) add_char(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic void add_partial(int k);
    add_char(ChBackslash);
    add_char(ChU);
    for (int i = 0; i < k; i++) add_char(hex_char(4'($urandom)));
  endfunction

  function automatic logic [15:0] high_value();
    return 16'(16'hD800 + pick_in(0, 'h3FF));
  endfunction

  function automatic logic [15:0] low_value();
    return 16'(16'hDC00 + pick_in(0, 'h3FF));
  endfunction

  function automatic logic [7:0] raw_text();
    logic [7:0] b;
    b = ChQuote;
    while (b == ChQuote || b == ChBackslash) b = 8'($urandom_range(8'h20, 8'hFF));
    return b;
  endfunction

  function automatic logic [7:0] simple_letter();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = ChQuote;
      1:       b = ChBackslash;
      2:       b = ChSlash;
      3:       b = ChB;
      4:       b = ChF;
      5:       b = ChN;
      6:       b = ChR;
      default: b = ChT;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] unknown_letter();
    logic [7:0] b;
    b = ChU;
    while (known_escape(b)) b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] bad_hex();
    logic [7:0] b;
    b = 8'h30;
    while (hex_digit(b) >= 0) b = 8'($urandom);
    return b;
  endfunction

  // One string literal: mostly well formed with random content, some broken or cut short.
  function automatic void gen_string();
    int          nseg;
    int          tail;
    logic        errored;
    logic [15:0] v;
    logic [7:0]  b;
    errored = 1'b0;

    // Occasional noise while the decoder waits for a quote.
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        b = ChQuote;
        while (b == ChQuote) b = 8'($urandom);
        add_char(b);
      end
    end
    add_char(ChQuote);

    nseg = $urandom_range(0, 6);
    for (int s = 0; s < nseg && !errored; s++) begin
      case ($urandom_range(0, 99)) inside
        [0:34]:  add_char(raw_text());
        [35:49]: begin
          add_char(ChBackslash);
          add_char(simple_letter());
        end
        [50:64]: begin
          case ($urandom_range(0, 4))
            0:       v = 16'(pick_in(0, 'h7F));
            1:       v = 16'(pick_in('h80, 'h7FF));
            2:       v = 16'(pick_in('h800, 'hD7FF));
            3:       v = 16'(pick_in('hE000, 'hFFFF));
            default: v = low_value();
          endcase
          add_hex(v);
        end
        [65:84]: begin
          add_hex(high_value());
          add_hex(low_value());
        end
        [85:94]: begin
          // High surrogate followed by something other than a low surrogate.
          add_hex(high_value());
          case ($urandom_range(0, 3))
            0: begin
              if ($urandom_range(0, 4) == 0) begin
                add_char(8'($urandom_range(0, 8'h1F)));
                errored = 1'b1;
              end else begin
                add_char(raw_text());
              end
            end
            1: begin
              add_char(ChBackslash);
              if ($urandom_range(0, 3) == 0) begin
                add_char(unknown_letter());
                errored = 1'b1;
              end else begin
                add_char(simple_letter());
              end
            end
            2: begin
              case ($urandom_range(0, 2))
                0:       v = high_value();
                1:       v = 16'(pick_in(0, 'hD7FF));
                default: v = 16'(pick_in('hE000, 'hFFFF));
              endcase
              add_hex(v);
            end
            default: begin
              add_partial($urandom_range(0, 3));
              add_char(bad_hex());
              errored = 1'b1;
            end
          endcase
        end
        default: begin
          // Broken first escape or raw control byte.
          case ($urandom_range(0, 2))
            0: add_char(8'($urandom_range(0, 8'h1F)));
            1: begin
              add_char(ChBackslash);
              add_char(unknown_letter());
            end
            default: begin
              add_partial($urandom_range(0, 3));
              add_char(bad_hex());
            end
          endcase
          errored = 1'b1;
        end
      endcase
    end

    if (errored) begin
      flush_string($urandom_range(0, 3) == 0);
    end else begin
      tail = $urandom_range(0, 99);
      if (tail < 75) begin
        add_char(ChQuote);
        flush_string($urandom_range(0, 3) == 0);
      end else if (tail < 85) begin
        flush_string(1'b1);
      end else begin
        // Cut short in the middle of an escape or of a surrogate pair.
        case ($urandom_range(0, 4))
          0: add_char(ChBackslash);
          1: add_partial($urandom_range(0, 3));
          2: add_hex(high_value());
          3: begin
            add_hex(high_value());
            add_char(ChBackslash);
          end
          default: begin
            add_hex(high_value());
            add_partial($urandom_range(0, 3));
          end
        endcase
        flush_string(1'b1);
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset and stimulus.
  // ---------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    // Directed: ignored byte while idle, 0xFF passed through, a simple escape,
    // a surrogate pair with mixed-case hex, a raw control byte, an unknown
    // escape, and text ending before its closing quote.
    add_char(8'h41);
    flush_string(1'b0);
    add_text("\"");
    add_char(8'hFF);
    add_text("\\t\\uD83d\\udE00\"");
    flush_string(1'b0);
    add_text("\"");
    add_char(8'h00);
    flush_string(1'b0);
    add_text("\"\\q");
    flush_string(1'b0);
    add_text("\"x");
    flush_string(1'b1);

    while (text_q.size() < ItemTarget) gen_string();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all text to go in and every decoded result to come out.
    @(posedge clk_i);
    while (text_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Sender: offers queued text bytes, idling at random outside a quiet window.
  always @(posedge clk_i or negedge rst_ni) begin : drive_text
    logic fire;
    logic quiet;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      in_byte_i   <= 8'h00;
      last_byte_i <= 1'b0;
    end else begin
      fire  = in_valid_i && in_ready_o;
      quiet = in_count >= 200 && in_count < 280;
      if (fire) begin
        decode_byte(in_byte_i, last_byte_i);
        in_count++;
      end
      if (in_valid_i && !fire) begin
        // Hold the current transaction until it is taken.
      end else if (text_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
        in_valid_i  <= 1'b1;
        in_byte_i   <= text_q[0].b;
        last_byte_i <= text_q[0].last;
        void'(text_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks each result transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : check_decoded
    decoded_t want;
    logic     quiet;
    int       hold_left;
    logic     held_off;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      held_off  = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        out_count++;
        if (decoded_q.size() == 0) begin
          report($sformatf("unexpected result: byte %02h status %0d run_end %0b",
                           out_byte_o, status_o, run_end_o));
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_o !== want.b) begin
            report($sformatf("result %0d: out_byte %02h, predicted %02h",
                             out_count, out_byte_o, want.b));
          end
          if (status_o !== want.st) begin
            report($sformatf("result %0d: status %0d, predicted %0d",
                             out_count, status_o, want.st));
          end
          if (run_end_o !== want.run_end) begin
            report($sformatf("result %0d: run_end %0b, predicted %0b",
                             out_count, run_end_o, want.run_end));
          end
        end
      end

      // One long hold-off so the internal queue fills and the input stalls.
      if (out_count >= HoldAt && !held_off) begin
        hold_left = HoldCycles;
        held_off  = 1'b1;
      end
      quiet = out_count >= 150 && out_count < 250;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || $urandom_range(0, 99) >= 15;
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
